>>> rtl/core/ap4_pkg.sv
// shared types and constants of the multichannel fourth-order allpass filter
`timescale 1ns / 1ps

package ap4_pkg;

   localparam int CHAN_W    = 3;
   localparam int SMP_W     = 24;
   localparam int COEF_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int DIFF_W    = SMP_W + 1;
   localparam int PROD_W    = COEF_W + DIFF_W;
   localparam int ACC_W     = 64;
   localparam int FRAC_SH   = 27;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd1 <<< (FRAC_SH - 1));
   localparam logic signed [SMP_W-1:0] SMP_MAX    = 24'sh7FFFFF;
   localparam logic signed [SMP_W-1:0] SMP_MIN    = 24'sh800000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_ONE   = 2'd0,
      CSR_COEF_TWO   = 2'd1,
      CSR_COEF_THREE = 2'd2,
      CSR_COEF_FOUR  = 2'd3
   } csr_idx_type;

   // one channel's history: previous inputs x1..x4 and outputs y1..y4
   typedef struct packed {
      logic signed [SMP_W-1:0] x1;
      logic signed [SMP_W-1:0] x2;
      logic signed [SMP_W-1:0] x3;
      logic signed [SMP_W-1:0] x4;
      logic signed [SMP_W-1:0] y1;
      logic signed [SMP_W-1:0] y2;
      logic signed [SMP_W-1:0] y3;
      logic signed [SMP_W-1:0] y4;
   } hist_type;

endpackage

>>> rtl/core/allpass4_multichannel_filter_top.sv
// multichannel fourth-order allpass filter, direct form I, history kept in one memory
//
// usage:
//   req channel: req_valid/req_stall with req_chan_in and req_sample_in (Q1.23).
//   rsp channel: rsp_valid/rsp_stall with rsp_chan_out and rsp_sample_out (Q1.23,
//   saturated). one rsp transaction for every req transaction, in order.
//   csr port: csr_we writes csr_wdata to coefficient csr_index (Q5.27), idle only.
//   the result passes through stage 1, stage 2 and the output register to rsp.
//   throughput: one transaction per cycle unless stalled; a transaction whose channel
//   equals the one just accepted waits, since y1 of the previous sample must come
//   back from the output adder before it enters the d1 multiplier.
//   the history memory has one read port (registered) and one write
//   port; the last write is forwarded to the read that overlaps it.
//   a channel at or above NUM_CHANNELS gives sample 0 and leaves history alone.
//   reset: synchronous, clears coefficients and per-channel valid bits at once,
//   so every history reads as zero right away; no clearing pass.
//   rsp_stall while rsp_valid is high freezes the whole pipeline and req_stall rises in the same cycle.
`timescale 1ns / 1ps

module allpass4_multichannel_filter_top #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ap4_pkg::CHAN_W-1:0]          req_chan_in,
   input  logic signed [ap4_pkg::SMP_W-1:0]    req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ap4_pkg::CHAN_W-1:0]          rsp_chan_out,
   output logic signed [ap4_pkg::SMP_W-1:0]    rsp_sample_out,
   input  logic                                csr_we,
   input  logic [ap4_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ap4_pkg::COEF_W-1:0]          csr_wdata
);
   import ap4_pkg::*;

   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // coefficients
   logic signed [COEF_W-1:0] coef_one_ff, coef_two_ff, coef_three_ff, coef_four_ff;

   // history memory and per-entry valid bits
   hist_type                  hist_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]   vld_ff;
   hist_type                  rd_data_ff;
   logic                      rd_vld_ff;

   // last write, forwarded to an overlapping read
   logic                      wb_valid_ff;
   logic [ADDR_W-1:0]         wb_addr_ff;
   hist_type                  wb_data_ff;

   // stage 1: memory data and multiply
   logic                      s1_valid_ff, s1_inrange_ff;
   logic [CHAN_W-1:0]         s1_chan_ff;
   logic [ADDR_W-1:0]         s1_addr_ff;
   logic signed [SMP_W-1:0]   s1_x_ff;

   // stage 2: sum, round, saturate, write back
   logic                      s2_valid_ff, s2_inrange_ff;
   logic [CHAN_W-1:0]         s2_chan_ff;
   logic [ADDR_W-1:0]         s2_addr_ff;
   logic signed [PROD_W-1:0]  p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [PROD_W-1:0]  p1_in, p2_in, p3_in, p4_in;
   logic signed [SMP_W-1:0]   s2_x4_ff;
   hist_type                  s2_hist_ff, s2_hist_in;

   // output register
   logic                      rsp_valid_ff;
   logic [CHAN_W-1:0]         rsp_chan_ff;
   logic signed [SMP_W-1:0]   rsp_sample_ff, rsp_sample_in;

   logic                      advance, hazard, accept, req_inrange, wr_en;
   logic [ADDR_W+CHAN_W-1:0]  req_chan_ext;
   logic [ADDR_W-1:0]         rd_addr;
   hist_type                  h_cur, wr_data;
   logic signed [DIFF_W-1:0]  diff1, diff2, diff3, diff4;
   logic signed [ACC_W-1:0]   acc, rnd, quo;
   logic signed [SMP_W-1:0]   y_sat;

   assign advance      = !rsp_valid_ff || !rsp_stall;
   // same channel as the item now in stage 1 must wait for its y1
   assign hazard       = s1_valid_ff && s1_inrange_ff &&
                         (req_chan_in == s1_chan_ff);
   assign req_stall    = !advance || hazard;
   assign accept       = req_valid && !req_stall;
   assign req_inrange  = int'(req_chan_in) < NUM_CHANNELS;
   assign req_chan_ext = {{ADDR_W{1'b0}}, req_chan_in};
   assign rd_addr      = req_chan_ext[ADDR_W-1:0];
   assign wr_en        = advance && s2_valid_ff && s2_inrange_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_one_ff   <= '0;
         coef_two_ff   <= '0;
         coef_three_ff <= '0;
         coef_four_ff  <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_COEF_ONE:   coef_one_ff   <= csr_wdata;
            CSR_COEF_TWO:   coef_two_ff   <= csr_wdata;
            CSR_COEF_THREE: coef_three_ff <= csr_wdata;
            CSR_COEF_FOUR:  coef_four_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[s2_addr_ff] <= wr_data;
      end
      if (advance) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[s2_addr_ff] <= 1'b1;
            wb_valid_ff        <= 1'b1;
         end
         if (advance) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wb_addr_ff <= s2_addr_ff;
         wb_data_ff <= wr_data;
      end
   end

   // stage 1 combinational: pick current history, differences and products
   always_comb begin
      if (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) begin
         h_cur = wb_data_ff;
      end else if (rd_vld_ff) begin
         h_cur = rd_data_ff;
      end else begin
         h_cur = '0;
      end
      diff1 = DIFF_W'(h_cur.x3) - DIFF_W'(h_cur.y1);
      diff2 = DIFF_W'(h_cur.x2) - DIFF_W'(h_cur.y2);
      diff3 = DIFF_W'(h_cur.x1) - DIFF_W'(h_cur.y3);
      diff4 = DIFF_W'(s1_x_ff)  - DIFF_W'(h_cur.y4);
      p1_in = PROD_W'(coef_one_ff)   * PROD_W'(diff1);
      p2_in = PROD_W'(coef_two_ff)   * PROD_W'(diff2);
      p3_in = PROD_W'(coef_three_ff) * PROD_W'(diff3);
      p4_in = PROD_W'(coef_four_ff)  * PROD_W'(diff4);
      s2_hist_in    = '0;
      s2_hist_in.x1 = s1_x_ff;
      s2_hist_in.x2 = h_cur.x1;
      s2_hist_in.x3 = h_cur.x2;
      s2_hist_in.x4 = h_cur.x3;
      s2_hist_in.y2 = h_cur.y1;
      s2_hist_in.y3 = h_cur.y2;
      s2_hist_in.y4 = h_cur.y3;
   end

   // stage 2 combinational: sum, round half up, saturate
   always_comb begin
      acc = ACC_W'(p1_ff) + ACC_W'(p2_ff) + ACC_W'(p3_ff) + ACC_W'(p4_ff) +
            (ACC_W'(s2_x4_ff) <<< FRAC_SH);
      rnd = acc + ROUND_BIAS;
      quo = rnd >>> FRAC_SH;
      if (quo > ACC_W'(SMP_MAX)) begin
         y_sat = SMP_MAX;
      end else if (quo < ACC_W'(SMP_MIN)) begin
         y_sat = SMP_MIN;
      end else begin
         y_sat = quo[SMP_W-1:0];
      end
      wr_data       = s2_hist_ff;
      wr_data.y1    = y_sat;
      rsp_sample_in = s2_inrange_ff ? y_sat : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inrange_ff <= req_inrange;
         s1_chan_ff    <= req_chan_in;
         s1_addr_ff    <= rd_addr;
         s1_x_ff       <= req_sample_in;
         s2_inrange_ff <= s1_inrange_ff;
         s2_chan_ff    <= s1_chan_ff;
         s2_addr_ff    <= s1_addr_ff;
         p1_ff         <= p1_in;
         p2_ff         <= p2_in;
         p3_ff         <= p3_in;
         p4_ff         <= p4_in;
         s2_x4_ff      <= h_cur.x4;
         s2_hist_ff    <= s2_hist_in;
         rsp_chan_ff   <= s2_chan_ff;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_chan_out   = rsp_chan_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef ASSERT_OFF
   // two in-range items of one channel never sit in adjacent stages
   a_no_same_chan: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s1_inrange_ff && s2_valid_ff && s2_inrange_ff &&
        (s1_addr_ff == s2_addr_ff)))
      else $error("same channel in stage 1 and stage 2");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transaction did not enter stage 1");

   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (int'(rsp_chan_out) >= NUM_CHANNELS)) |-> (rsp_sample_out == '0))
      else $error("out-of-range channel gave nonzero sample");

   a_wr_stage2: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (wb_valid_ff && (wb_addr_ff == $past(s2_addr_ff))))
      else $error("writeback forwarding register not updated");
`endif

endmodule
